### sv/tamgt_pkg.sv
// Shared types, constants and helper functions for the two-axis max gap tracker.
package tamgt_pkg;

	localparam int LEN_W   = 11;
	localparam int POS_W   = 10;
	localparam int AREA_W  = 21;
	localparam int WORD_W  = 32;
	localparam int WIDX_W  = 6;
	localparam int CLR_W   = 12;

	localparam logic [LEN_W-1:0] MAX_LEN = 11'd1024;
	localparam logic [LEN_W-1:0] MIN_LEN = 11'd2;

	// axis codes (operation field)
	localparam logic AX_H = 1'b0;
	localparam logic AX_W = 1'b1;

	// register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;

	// datapath operations
	localparam logic [3:0] OP_NOP     = 4'd0;
	localparam logic [3:0] OP_LOAD    = 4'd1;
	localparam logic [3:0] OP_CFG     = 4'd2;
	localparam logic [3:0] OP_CLR     = 4'd3;
	localparam logic [3:0] OP_MAP_RD  = 4'd4;
	localparam logic [3:0] OP_MAP_CHK = 4'd5;
	localparam logic [3:0] OP_LO_RD   = 4'd6;
	localparam logic [3:0] OP_LO_CHK  = 4'd7;
	localparam logic [3:0] OP_HI_RD   = 4'd8;
	localparam logic [3:0] OP_HI_CHK  = 4'd9;
	localparam logic [3:0] OP_CNT_RD  = 4'd10;
	localparam logic [3:0] OP_CNT_WR  = 4'd11;
	localparam logic [3:0] OP_SCAN    = 4'd12;
	localparam logic [3:0] OP_OUT     = 4'd13;

	typedef struct packed {
		logic [3:0] op;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic hit;
		logic lo_hit;
		logic hi_hit;
		logic any;
		logic hi_fnd;
		logic cnt_last;
		logic need_scan;
		logic scan_done;
		logic clr_done;
		logic out_free;
	} stat_t;

	function automatic logic [4:0] msb32(input logic [WORD_W-1:0] v);
		logic [4:0] r;
		r = 5'd0;
		for (int i = 0; i < WORD_W; i++) begin
			if (v[i]) r = 5'(i);
		end
		return r;
	endfunction

	function automatic logic [4:0] lsb32(input logic [WORD_W-1:0] v);
		logic [4:0] r;
		r = 5'd0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) r = 5'(i);
		end
		return r;
	endfunction

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] r;
		r = v;
		if (v < MIN_LEN) r = MIN_LEN;
		if (v > MAX_LEN) r = MAX_LEN;
		return r;
	endfunction

endpackage

### sv/tamgt_ctrl.sv
// Controller state machine sequencing cuts, clearing sweeps and result hand-off.
module tamgt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	output logic              s_ready,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  tamgt_pkg::stat_t  st,
	output tamgt_pkg::cmd_t   cmd
);

	localparam logic [3:0] S_CLR     = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_MAP_RD  = 4'd2;
	localparam logic [3:0] S_MAP_CHK = 4'd3;
	localparam logic [3:0] S_LO_RD   = 4'd4;
	localparam logic [3:0] S_LO_CHK  = 4'd5;
	localparam logic [3:0] S_HI_RD   = 4'd6;
	localparam logic [3:0] S_HI_CHK  = 4'd7;
	localparam logic [3:0] S_CNT_RD  = 4'd8;
	localparam logic [3:0] S_CNT_WR  = 4'd9;
	localparam logic [3:0] S_SCAN    = 4'd10;
	localparam logic [3:0] S_FIN     = 4'd11;

	logic [3:0] state_q, state_d;

	assign cfg_ready = (state_q == S_IDLE);
	assign s_ready   = (state_q == S_IDLE) && !cfg_valid;

	always_comb begin
		state_d = state_q;
		cmd.op  = tamgt_pkg::OP_NOP;
		case (state_q)
			S_CLR: begin
				cmd.op = tamgt_pkg::OP_CLR;
				if (st.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (cfg_valid) begin
					cmd.op = tamgt_pkg::OP_CFG;
					if (cfg_index == tamgt_pkg::REG_WIDTH || cfg_index == tamgt_pkg::REG_HEIGHT)
						state_d = S_CLR;
				end else if (s_valid) begin
					cmd.op  = tamgt_pkg::OP_LOAD;
					state_d = S_MAP_RD;
				end
			end
			S_MAP_RD: begin
				if (st.bad) begin
					state_d = S_FIN;
				end else begin
					cmd.op  = tamgt_pkg::OP_MAP_RD;
					state_d = S_MAP_CHK;
				end
			end
			S_MAP_CHK: begin
				cmd.op = tamgt_pkg::OP_MAP_CHK;
				if (st.hit)         state_d = S_FIN;
				else if (!st.lo_hit) state_d = S_LO_RD;
				else if (!st.hi_hit) state_d = S_HI_RD;
				else                 state_d = S_CNT_RD;
			end
			S_LO_RD: begin
				cmd.op  = tamgt_pkg::OP_LO_RD;
				state_d = S_LO_CHK;
			end
			S_LO_CHK: begin
				cmd.op = tamgt_pkg::OP_LO_CHK;
				if (!st.any)        state_d = S_LO_RD;
				else if (!st.hi_fnd) state_d = S_HI_RD;
				else                 state_d = S_CNT_RD;
			end
			S_HI_RD: begin
				cmd.op  = tamgt_pkg::OP_HI_RD;
				state_d = S_HI_CHK;
			end
			S_HI_CHK: begin
				cmd.op  = tamgt_pkg::OP_HI_CHK;
				state_d = st.any ? S_CNT_RD : S_HI_RD;
			end
			S_CNT_RD: begin
				cmd.op  = tamgt_pkg::OP_CNT_RD;
				state_d = S_CNT_WR;
			end
			S_CNT_WR: begin
				cmd.op = tamgt_pkg::OP_CNT_WR;
				if (!st.cnt_last)     state_d = S_CNT_RD;
				else if (st.need_scan) state_d = S_SCAN;
				else                   state_d = S_FIN;
			end
			S_SCAN: begin
				cmd.op = tamgt_pkg::OP_SCAN;
				if (st.scan_done) state_d = S_FIN;
			end
			S_FIN: begin
				if (st.out_free) begin
					cmd.op  = tamgt_pkg::OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else         state_q <= state_d;
	end

endmodule

### sv/tamgt_dp.sv
// Datapath: cut maps, gap count memory, axis maxima and the result register.
module tamgt_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tamgt_pkg::cmd_t              cmd,
	output tamgt_pkg::stat_t             st,
	input  logic                         in_op,
	input  logic [tamgt_pkg::POS_W-1:0]  in_pos,
	input  logic [1:0]                   cfg_index,
	input  logic [tamgt_pkg::LEN_W-1:0]  cfg_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [tamgt_pkg::AREA_W-1:0] out_area,
	output logic [tamgt_pkg::LEN_W-1:0]  out_wgap,
	output logic [tamgt_pkg::LEN_W-1:0]  out_hgap,
	output logic                         out_ign
);

	localparam int LW = tamgt_pkg::LEN_W;
	localparam int WW = tamgt_pkg::WORD_W;
	localparam int XW = tamgt_pkg::WIDX_W;

	logic [WW-1:0] map_mem [0:(1 << (XW + 1)) - 1];
	logic [LW-1:0] cnt_mem [0:(1 << (LW + 1)) - 1];
	logic [WW-1:0] map_rd_q;
	logic [LW-1:0] cnt_rd_q;

	logic [LW-1:0] len_q [0:1];
	logic [LW-1:0] mx_q  [0:1];
	logic          ax_q;
	logic [tamgt_pkg::POS_W-1:0] pos_q;
	logic          bad_q, ign_q, hi_fnd_q, zero_q, pend_q;
	logic [XW-1:0] lw_q, hw_q;
	logic [LW-1:0] lo_q, hi_q, g_q, chk_q;
	logic [1:0]    k_q;
	logic [1:0]    mask_q;
	logic [tamgt_pkg::CLR_W-1:0] clr_q;

	logic [XW:0]   map_ra;
	logic [LW:0]   cnt_ra;
	logic [WW-1:0] lower, upper, bitpos;
	logic [XW-1:0] pw;
	logic [LW-1:0] old_gap, left_gap, right_gap;
	logic          clr_ax;
	logic [LW-1:0] clr_idx;
	logic [WW-1:0] clr_word;
	logic [LW-1:0] cfg_len;
	logic [2*LW-1:0] prod;

	assign pw        = {1'b0, pos_q[9:5]};
	assign bitpos    = WW'(1) << pos_q[4:0];
	assign lower     = map_rd_q & (bitpos - WW'(1));
	assign upper     = map_rd_q & ~((bitpos << 1) - WW'(1));
	assign old_gap   = hi_q - lo_q;
	assign left_gap  = {1'b0, pos_q} - lo_q;
	assign right_gap = hi_q - {1'b0, pos_q};
	assign clr_ax    = clr_q[LW];
	assign clr_idx   = clr_q[LW-1:0];
	assign cfg_len   = tamgt_pkg::clamp_len(cfg_data);
	assign clr_word  = (clr_idx == '0 ? WW'(1) : WW'(0)) |
		(clr_idx[XW-1:0] == len_q[clr_ax][LW-1:5] ? (WW'(1) << len_q[clr_ax][4:0]) : WW'(0));
	assign prod      = mx_q[1] * mx_q[0];

	always_comb begin
		map_ra = {ax_q, pw};
		case (cmd.op)
			tamgt_pkg::OP_LO_RD: map_ra = {ax_q, lw_q - XW'(1)};
			tamgt_pkg::OP_HI_RD: map_ra = {ax_q, hw_q + XW'(1)};
			default:             map_ra = {ax_q, pw};
		endcase
		cnt_ra = {ax_q, g_q};
		case (cmd.op)
			tamgt_pkg::OP_CNT_RD, tamgt_pkg::OP_CNT_WR: begin
				case (k_q)
					2'd0:    cnt_ra = {ax_q, old_gap};
					2'd1:    cnt_ra = {ax_q, left_gap};
					default: cnt_ra = {ax_q, right_gap};
				endcase
			end
			default: cnt_ra = {ax_q, g_q};
		endcase
	end

	always_comb begin
		st.bad       = bad_q;
		st.hit       = (map_rd_q & bitpos) != '0;
		st.lo_hit    = lower != '0;
		st.hi_hit    = upper != '0;
		st.any       = map_rd_q != '0;
		st.hi_fnd    = hi_fnd_q;
		st.cnt_last  = (k_q == 2'd2);
		st.need_scan = zero_q && (old_gap == mx_q[ax_q]);
		st.scan_done = pend_q && (cnt_rd_q != '0 || chk_q == '0);
		st.clr_done  = (clr_q == '1);
		st.out_free  = !out_valid || out_ready;
	end

	// memories
	always_ff @(posedge clk) begin
		map_rd_q <= map_mem[map_ra];
		cnt_rd_q <= cnt_mem[cnt_ra];
		if (cmd.op == tamgt_pkg::OP_CLR && mask_q[clr_ax]) begin
			cnt_mem[clr_q] <= (clr_idx == len_q[clr_ax]) ? LW'(1) : LW'(0);
			if (clr_idx[LW-1:XW] == '0) map_mem[{clr_ax, clr_idx[XW-1:0]}] <= clr_word;
		end
		if (cmd.op == tamgt_pkg::OP_MAP_CHK && !st.hit)
			map_mem[{ax_q, pw}] <= map_rd_q | bitpos;
		if (cmd.op == tamgt_pkg::OP_CNT_WR)
			cnt_mem[cnt_ra] <= (k_q == 2'd0) ? cnt_rd_q - LW'(1) : cnt_rd_q + LW'(1);
	end

	// item payload
	always_ff @(posedge clk) begin
		case (cmd.op)
			tamgt_pkg::OP_LOAD: begin
				ax_q  <= in_op;
				pos_q <= in_pos;
			end
			tamgt_pkg::OP_MAP_CHK: begin
				lw_q <= pw;
				hw_q <= pw;
				lo_q <= {pw, tamgt_pkg::msb32(lower)};
				hi_q <= {pw, tamgt_pkg::lsb32(upper)};
			end
			tamgt_pkg::OP_LO_RD: lw_q <= lw_q - XW'(1);
			tamgt_pkg::OP_HI_RD: hw_q <= hw_q + XW'(1);
			tamgt_pkg::OP_LO_CHK: lo_q <= {lw_q, tamgt_pkg::msb32(map_rd_q)};
			tamgt_pkg::OP_HI_CHK: hi_q <= {hw_q, tamgt_pkg::lsb32(map_rd_q)};
			tamgt_pkg::OP_CNT_WR: begin
				if (k_q == 2'd0) zero_q <= (cnt_rd_q == LW'(1));
				g_q <= old_gap - LW'(1);
			end
			tamgt_pkg::OP_SCAN: begin
				g_q   <= g_q - LW'(1);
				chk_q <= g_q;
			end
			tamgt_pkg::OP_OUT: begin
				out_area <= prod[tamgt_pkg::AREA_W-1:0];
				out_wgap <= mx_q[1];
				out_hgap <= mx_q[0];
				out_ign  <= ign_q;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q[0]  <= tamgt_pkg::MAX_LEN;
			len_q[1]  <= tamgt_pkg::MAX_LEN;
			mx_q[0]   <= tamgt_pkg::MAX_LEN;
			mx_q[1]   <= tamgt_pkg::MAX_LEN;
			mask_q    <= 2'b11;
			clr_q     <= '0;
			bad_q     <= 1'b0;
			ign_q     <= 1'b0;
			hi_fnd_q  <= 1'b0;
			pend_q    <= 1'b0;
			k_q       <= 2'd0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.op == tamgt_pkg::OP_OUT) out_valid <= 1'b1;
			else if (out_ready)              out_valid <= 1'b0;
			case (cmd.op)
				tamgt_pkg::OP_CFG: begin
					clr_q <= '0;
					if (cfg_index == tamgt_pkg::REG_WIDTH) begin
						len_q[tamgt_pkg::AX_W] <= cfg_len;
						mx_q[tamgt_pkg::AX_W]  <= cfg_len;
						mask_q <= 2'b10;
					end else if (cfg_index == tamgt_pkg::REG_HEIGHT) begin
						len_q[tamgt_pkg::AX_H] <= cfg_len;
						mx_q[tamgt_pkg::AX_H]  <= cfg_len;
						mask_q <= 2'b01;
					end
				end
				tamgt_pkg::OP_CLR: clr_q <= clr_q + 1'b1;
				tamgt_pkg::OP_LOAD: begin
					bad_q <= (in_pos == '0) || ({1'b0, in_pos} >= len_q[in_op]);
					ign_q <= (in_pos == '0) || ({1'b0, in_pos} >= len_q[in_op]);
					k_q   <= 2'd0;
				end
				tamgt_pkg::OP_MAP_CHK: begin
					ign_q    <= st.hit;
					hi_fnd_q <= st.hi_hit;
				end
				tamgt_pkg::OP_CNT_WR: begin
					k_q    <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
					pend_q <= 1'b0;
				end
				tamgt_pkg::OP_SCAN: begin
					pend_q <= 1'b1;
					if (st.scan_done) mx_q[ax_q] <= chk_q;
				end
				default: ;
			endcase
		end
	end

endmodule

### sv/two_axis_max_gap_tracker_core.sv
// Top level of the two-axis max gap tracker: controller plus datapath.
//  channel  | direction | handshake                   | payload
//  s_axis   | in        | s_axis_tvalid/s_axis_tready | tdata: cut_position; tuser: operation
//  m_axis   | out       | m_axis_tvalid/m_axis_tready | tdata: area, width gap, height gap; tuser: cut_ignored
//  cfg      | in        | cfg_valid/cfg_ready         | cfg_index, cfg_data
// One item at a time: extra map words are searched below and above the cut as needed, the gap
// counts are updated, and a downward count scan runs when the maximum gap disappears.
// A cut out of range skips the map search; a repeated cut ends after the map check.
// The search walks 32-bit words of the cut map; the scan walks the gap count memory.
// After reset and after each size write a clearing pass re-initialises the cut map and gap counts.
// A stalled result register holds; an item finishing while it is still full waits.
module two_axis_max_gap_tracker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [9:0] cut_position
	input  logic        s_axis_tuser,   // [0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [20:0] largest_area, [31:21] largest_width_gap, [42:32] largest_height_gap
	output logic        m_axis_tuser,   // [0] cut_ignored
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	tamgt_pkg::cmd_t  cmd;
	tamgt_pkg::stat_t st;
	logic [tamgt_pkg::AREA_W-1:0] area;
	logic [tamgt_pkg::LEN_W-1:0]  wgap, hgap;

	tamgt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_axis_tvalid),
		.s_ready   (s_axis_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.st        (st),
		.cmd       (cmd)
	);

	tamgt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_op     (s_axis_tuser),
		.in_pos    (s_axis_tdata[9:0]),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_area  (area),
		.out_wgap  (wgap),
		.out_hgap  (hgap),
		.out_ign   (m_axis_tuser)
	);

	assign m_axis_tdata = {5'd0, hgap, wgap, area};

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item accepted while previous one in progress");
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index == tamgt_pkg::REG_WIDTH ||
		cfg_index == tamgt_pkg::REG_HEIGHT) |=> !cfg_ready)
		else $error("size write did not start clearing");
	a_area: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[20:0] ==
		21'(m_axis_tdata[31:21]) * 21'(m_axis_tdata[42:32]))
		else $error("area does not match gaps");
`endif

endmodule
